// File: hw/rtl/rcrt_pkg.sv
package rcrt_pkg;

    // configuration address decode
    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_VEHICLE_X   = 3'd0,
        REG_VEHICLE_Y   = 3'd1,
        REG_VEHICLE_Z   = 3'd2,
        REG_ROT_ABOUT_X = 3'd3,
        REG_ROT_ABOUT_Y = 3'd4,
        REG_ROT_ABOUT_Z = 3'd5,
        REG_KEEP_RADIUS = 3'd6
    } t_reg_idx;

    // register reset values
    localparam logic [31:0] ROT_RESET    = 32'h4000_0000;
    localparam logic [15:0] RADIUS_RESET = 16'd10;

    // coordinate widths inside the datapath
    localparam int NEAR_W = 25;   // planar difference once the far check has passed
    localparam int DIFF_W = 33;   // exact difference of two 32 bit values
    localparam int SQ_W   = 48;   // square of a near difference

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               lane_side;
    } t_point_in;

    typedef struct packed {
        logic signed [31:0] local_x;
        logic signed [31:0] local_y;
        logic signed [31:0] local_z;
        logic               lane_side_out;
    } t_point_out;

    typedef struct packed {
        logic signed [31:0] vehicle_x;
        logic signed [31:0] vehicle_y;
        logic signed [31:0] vehicle_z;
        logic [31:0]        rot_about_x;
        logic [31:0]        rot_about_y;
        logic [31:0]        rot_about_z;
        logic [15:0]        keep_radius;
    } t_cfg;

    // kept point, translated, waiting for the rotation pipeline
    typedef struct packed {
        logic signed [NEAR_W-1:0] dx;
        logic signed [NEAR_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
        logic                     lane_side;
    } t_mid_item;

    // occupancy of the front pipeline
    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
    } t_front_status;

endpackage

// File: hw/rtl/rcrt_cfg.sv
module rcrt_cfg
    import rcrt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vehicle_x   <= '0;
            r_cfg.vehicle_y   <= '0;
            r_cfg.vehicle_z   <= '0;
            r_cfg.rot_about_x <= ROT_RESET;
            r_cfg.rot_about_y <= ROT_RESET;
            r_cfg.rot_about_z <= ROT_RESET;
            r_cfg.keep_radius <= RADIUS_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_VEHICLE_X:   r_cfg.vehicle_x   <= pwdata;
                REG_VEHICLE_Y:   r_cfg.vehicle_y   <= pwdata;
                REG_VEHICLE_Z:   r_cfg.vehicle_z   <= pwdata;
                REG_ROT_ABOUT_X: r_cfg.rot_about_x <= pwdata;
                REG_ROT_ABOUT_Y: r_cfg.rot_about_y <= pwdata;
                REG_ROT_ABOUT_Z: r_cfg.rot_about_z <= pwdata;
                REG_KEEP_RADIUS: r_cfg.keep_radius <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_VEHICLE_X:   prdata = r_cfg.vehicle_x;
            REG_VEHICLE_Y:   prdata = r_cfg.vehicle_y;
            REG_VEHICLE_Z:   prdata = r_cfg.vehicle_z;
            REG_ROT_ABOUT_X: prdata = r_cfg.rot_about_x;
            REG_ROT_ABOUT_Y: prdata = r_cfg.rot_about_y;
            REG_ROT_ABOUT_Z: prdata = r_cfg.rot_about_z;
            REG_KEEP_RADIUS: prdata = {16'd0, r_cfg.keep_radius};
            default:         prdata = '0;
        endcase
    end

endmodule

// File: hw/rtl/rcrt_fifo.sv
module rcrt_fifo #(
    parameter int WIDTH   = 84,
    parameter int DEPTH_W = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic [DEPTH_W:0] o_count
);

    logic [WIDTH-1:0]   r_mem [1 << DEPTH_W];
    logic [DEPTH_W-1:0] r_wr_ptr;
    logic [DEPTH_W-1:0] r_rd_ptr;
    logic [DEPTH_W:0]   r_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: hw/rtl/rcrt_front.sv
module rcrt_front
    import rcrt_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  t_point_in     i_point,
    input  t_cfg          i_cfg,
    output logic          o_push,
    output t_mid_item     o_item,
    output t_front_status o_status
);

    // stage 1: differences to the vehicle position
    logic                     r_s1_valid;
    logic signed [DIFF_W-1:0] r_s1_dx;
    logic signed [DIFF_W-1:0] r_s1_dy;
    logic signed [DIFF_W-1:0] r_s1_dz;
    logic                     r_s1_lane;

    // stage 2: squares and reach check
    logic              r_s2_valid;
    logic              r_s2_near;
    logic [SQ_W-1:0]   r_s2_sqx;
    logic [SQ_W-1:0]   r_s2_sqy;
    logic [31:0]       r_s2_rad_sq;
    t_mid_item         r_s2_item;

    logic                       w_near_x;
    logic                       w_near_y;
    logic signed [2*NEAR_W-1:0] w_sqx;
    logic signed [2*NEAR_W-1:0] w_sqy;
    logic [SQ_W:0]              w_sum;
    logic [SQ_W:0]              w_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_dx   <= DIFF_W'(i_point.point_x) - DIFF_W'(i_cfg.vehicle_x);
        r_s1_dy   <= DIFF_W'(i_point.point_y) - DIFF_W'(i_cfg.vehicle_y);
        r_s1_dz   <= DIFF_W'(i_point.point_z) - DIFF_W'(i_cfg.vehicle_z);
        r_s1_lane <= i_point.lane_side;
    end

    // strictly inside +-2^24: upper bits are pure sign, and not exactly -2^24
    assign w_near_x = ((r_s1_dx[DIFF_W-1:NEAR_W-1] == '0) ||
                       (r_s1_dx[DIFF_W-1:NEAR_W-1] == '1)) &&
                      !((r_s1_dx[DIFF_W-1:NEAR_W-1] == '1) && (r_s1_dx[NEAR_W-2:0] == '0));
    assign w_near_y = ((r_s1_dy[DIFF_W-1:NEAR_W-1] == '0) ||
                       (r_s1_dy[DIFF_W-1:NEAR_W-1] == '1)) &&
                      !((r_s1_dy[DIFF_W-1:NEAR_W-1] == '1) && (r_s1_dy[NEAR_W-2:0] == '0));

    // signed squares of the near differences
    assign w_sqx = $signed(r_s1_dx[NEAR_W-1:0]) * $signed(r_s1_dx[NEAR_W-1:0]);
    assign w_sqy = $signed(r_s1_dy[NEAR_W-1:0]) * $signed(r_s1_dy[NEAR_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_near           <= w_near_x && w_near_y;
        r_s2_sqx            <= w_sqx[SQ_W-1:0];
        r_s2_sqy            <= w_sqy[SQ_W-1:0];
        r_s2_rad_sq         <= i_cfg.keep_radius * i_cfg.keep_radius;
        r_s2_item.dx        <= r_s1_dx[NEAR_W-1:0];
        r_s2_item.dy        <= r_s1_dy[NEAR_W-1:0];
        r_s2_item.dz        <= r_s1_dz;
        r_s2_item.lane_side <= r_s1_lane;
    end

    // stage 3: radius compare, (radius * 256)^2 is radius^2 shifted by 16
    assign w_sum = {1'b0, r_s2_sqx} + {1'b0, r_s2_sqy};
    assign w_lim = {1'b0, r_s2_rad_sq, 16'd0};

    assign o_push          = r_s2_valid && r_s2_near && (w_sum <= w_lim);
    assign o_item          = r_s2_item;
    assign o_status.s1_valid = r_s1_valid;
    assign o_status.s2_valid = r_s2_valid;

endmodule

// File: hw/rtl/rcrt_back.sv
module rcrt_back
    import rcrt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  t_mid_item  i_item,
    input  t_cfg       i_cfg,
    output logic       o_push,
    output t_point_out o_result,
    output logic [2:0] o_inflight
);

    function automatic logic signed [31:0] sat42(input logic signed [41:0] v);
        logic signed [31:0] res;
        if ((v[41:31] == '0) || (v[41:31] == '1)) begin
            res = v[31:0];
        end else if (v[41]) begin
            res = 32'sh8000_0000;
        end else begin
            res = 32'sh7fff_ffff;
        end
        return res;
    endfunction

    logic signed [15:0] w_cx, w_sx, w_cy, w_sy, w_cz, w_sz;

    // rotation about x: products
    logic               r_p1_valid;
    logic               r_p1_lane;
    logic signed [24:0] r_p1_x;
    logic signed [40:0] r_p1_yc;
    logic signed [48:0] r_p1_zs;
    logic signed [48:0] r_p1_zc;
    logic signed [40:0] r_p1_ys;

    // rotation about x: sums
    logic               r_s1_valid;
    logic               r_s1_lane;
    logic signed [24:0] r_s1_x;
    logic signed [35:0] r_s1_y;
    logic signed [35:0] r_s1_z;
    logic signed [49:0] w_sum1_y;
    logic signed [49:0] w_sum1_z;

    // rotation about y: products
    logic               r_p2_valid;
    logic               r_p2_lane;
    logic signed [35:0] r_p2_y;
    logic signed [40:0] r_p2_xc;
    logic signed [51:0] r_p2_zs;
    logic signed [40:0] r_p2_xs;
    logic signed [51:0] r_p2_zc;

    // rotation about y: sums
    logic               r_s2_valid;
    logic               r_s2_lane;
    logic signed [38:0] r_s2_x;
    logic signed [35:0] r_s2_y;
    logic signed [38:0] r_s2_z;
    logic signed [52:0] w_sum2_x;
    logic signed [52:0] w_sum2_z;

    // rotation about z: products
    logic               r_p3_valid;
    logic               r_p3_lane;
    logic signed [38:0] r_p3_z;
    logic signed [54:0] r_p3_xc;
    logic signed [51:0] r_p3_ys;
    logic signed [51:0] r_p3_yc;
    logic signed [54:0] r_p3_xs;
    logic signed [55:0] w_sum3_x;
    logic signed [55:0] w_sum3_y;

    assign w_cx = i_cfg.rot_about_x[31:16];
    assign w_sx = i_cfg.rot_about_x[15:0];
    assign w_cy = i_cfg.rot_about_y[31:16];
    assign w_sy = i_cfg.rot_about_y[15:0];
    assign w_cz = i_cfg.rot_about_z[31:16];
    assign w_sz = i_cfg.rot_about_z[15:0];

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
        end else begin
            r_p1_valid <= i_take;
            r_s1_valid <= r_p1_valid;
            r_p2_valid <= r_s1_valid;
            r_s2_valid <= r_p2_valid;
            r_p3_valid <= r_s2_valid;
        end
    end

    // x rotation products
    always_ff @(posedge i_clk) begin
        r_p1_lane <= i_item.lane_side;
        r_p1_x    <= i_item.dx;
        r_p1_yc   <= i_item.dy * w_cx;
        r_p1_zs   <= i_item.dz * w_sx;
        r_p1_zc   <= i_item.dz * w_cx;
        r_p1_ys   <= i_item.dy * w_sx;
    end

    // x rotation sums, round half up on 14 fraction bits
    assign w_sum1_y = 50'(r_p1_yc) + 50'(r_p1_zs) + 50'sd8192;
    assign w_sum1_z = 50'(r_p1_zc) - 50'(r_p1_ys) + 50'sd8192;

    always_ff @(posedge i_clk) begin
        r_s1_lane <= r_p1_lane;
        r_s1_x    <= r_p1_x;
        r_s1_y    <= w_sum1_y[49:14];
        r_s1_z    <= w_sum1_z[49:14];
    end

    // y rotation products
    always_ff @(posedge i_clk) begin
        r_p2_lane <= r_s1_lane;
        r_p2_y    <= r_s1_y;
        r_p2_xc   <= r_s1_x * w_cy;
        r_p2_zs   <= r_s1_z * w_sy;
        r_p2_xs   <= r_s1_x * w_sy;
        r_p2_zc   <= r_s1_z * w_cy;
    end

    // y rotation sums
    assign w_sum2_x = 53'(r_p2_xc) - 53'(r_p2_zs) + 53'sd8192;
    assign w_sum2_z = 53'(r_p2_xs) + 53'(r_p2_zc) + 53'sd8192;

    always_ff @(posedge i_clk) begin
        r_s2_lane <= r_p2_lane;
        r_s2_y    <= r_p2_y;
        r_s2_x    <= w_sum2_x[52:14];
        r_s2_z    <= w_sum2_z[52:14];
    end

    // z rotation products
    always_ff @(posedge i_clk) begin
        r_p3_lane <= r_s2_lane;
        r_p3_z    <= r_s2_z;
        r_p3_xc   <= r_s2_x * w_cz;
        r_p3_ys   <= r_s2_y * w_sz;
        r_p3_yc   <= r_s2_y * w_cz;
        r_p3_xs   <= r_s2_x * w_sz;
    end

    // z rotation sums and saturation into the output queue
    assign w_sum3_x = 56'(r_p3_xc) + 56'(r_p3_ys) + 56'sd8192;
    assign w_sum3_y = 56'(r_p3_yc) - 56'(r_p3_xs) + 56'sd8192;

    assign o_push                 = r_p3_valid;
    assign o_result.local_x       = sat42(w_sum3_x[55:14]);
    assign o_result.local_y       = sat42(w_sum3_y[55:14]);
    assign o_result.local_z       = sat42(42'(r_p3_z));
    assign o_result.lane_side_out = r_p3_lane;

    assign o_inflight = 3'(r_p1_valid) + 3'(r_s1_valid) + 3'(r_p2_valid)
                      + 3'(r_s2_valid) + 3'(r_p3_valid);

endmodule

// File: hw/rtl/radius_crop_rigid_transform_core.sv
// Radius crop and inverse rigid transform of lane map points.
// Input side is a queue: drive i_point and raise push while full is low;
// each transfer is one map point with its lane tag. Result side is a
// queue too: while empty is low, o_local holds the oldest result and a
// pop transfer takes it. A point farther than keep_radius from the
// vehicle in x and y gives no result; a kept point comes out translated
// by minus the vehicle position and rotated about x, y and z in turn.
// Throughput is one point per cycle while full is low. A kept point passes
// 2 front stages (difference, square and reach check), the middle queue
// write after the radius compare, and 5 back stages (products and sums for
// the x and y rotations, products for z, whose sums and saturation feed
// the output queue). Results come out in input order. When the receiver
// stalls, the output queue fills, the back stops drawing from the middle
// queue, and full rises once the middle queue plus the front stages hold
// MID_DEPTH points. Set registers through the APB port only while the
// block is idle; the block does not enforce it. Reset empties both queues
// and loads vehicle position 0, zero angles and a 10 m radius.
module radius_crop_rigid_transform_core
    import rcrt_pkg::*;
#(
    parameter int MID_DEPTH_W = 3,
    parameter int OUT_DEPTH_W = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  t_point_in         i_point,
    output logic              empty,
    input  logic              pop,
    output t_point_out        o_local,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int MID_DEPTH = 1 << MID_DEPTH_W;
    localparam int OUT_DEPTH = 1 << OUT_DEPTH_W;

    t_cfg                 w_cfg;
    t_front_status        w_front_stat;
    logic                 w_in_accept;
    logic                 w_mid_push;
    logic                 w_mid_pop;
    t_mid_item            w_mid_in;
    t_mid_item            w_mid_out;
    logic [MID_DEPTH_W:0] w_mid_count;
    logic [MID_DEPTH_W+1:0] w_mid_load;
    logic                 w_out_push;
    logic                 w_out_pop;
    t_point_out           w_out_in;
    logic [OUT_DEPTH_W:0] w_out_count;
    logic [OUT_DEPTH_W+1:0] w_out_load;
    logic [2:0]           w_back_inflight;

    rcrt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // front admission: middle queue plus points still in the front stages
    assign w_mid_load  = (MID_DEPTH_W+2)'(w_mid_count)
                       + (MID_DEPTH_W+2)'(w_front_stat.s1_valid)
                       + (MID_DEPTH_W+2)'(w_front_stat.s2_valid);
    assign full        = (w_mid_load >= (MID_DEPTH_W+2)'(MID_DEPTH));
    assign w_in_accept = push && !full;

    rcrt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_in_accept),
        .i_point  (i_point),
        .i_cfg    (w_cfg),
        .o_push   (w_mid_push),
        .o_item   (w_mid_in),
        .o_status (w_front_stat)
    );

    rcrt_fifo #(
        .WIDTH   ($bits(t_mid_item)),
        .DEPTH_W (MID_DEPTH_W)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_mid_in),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_out),
        .o_count (w_mid_count)
    );

    // back draws a point when the output queue has room for all in flight
    assign w_out_load = (OUT_DEPTH_W+2)'(w_out_count) + (OUT_DEPTH_W+2)'(w_back_inflight);
    assign w_mid_pop  = (w_mid_count != '0) && (w_out_load < (OUT_DEPTH_W+2)'(OUT_DEPTH));

    rcrt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (w_mid_pop),
        .i_item     (w_mid_out),
        .i_cfg      (w_cfg),
        .o_push     (w_out_push),
        .o_result   (w_out_in),
        .o_inflight (w_back_inflight)
    );

    rcrt_fifo #(
        .WIDTH   ($bits(t_point_out)),
        .DEPTH_W (OUT_DEPTH_W)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_in),
        .i_pop   (w_out_pop),
        .o_data  (o_local),
        .o_count (w_out_count)
    );

    // result side
    assign empty     = (w_out_count == '0);
    assign w_out_pop = pop && !empty;

`ifndef NO_ASSERTIONS
    a_mid_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_push |-> (w_mid_count < (MID_DEPTH_W+1)'(MID_DEPTH)) || w_mid_pop)
        else $error("middle queue written while full");

    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_push |-> (w_out_count < (OUT_DEPTH_W+1)'(OUT_DEPTH)) || w_out_pop)
        else $error("output queue written while full");

    a_accept_enters_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> w_front_stat.s1_valid)
        else $error("accepted point did not enter the front pipeline");

    a_back_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load <= (OUT_DEPTH_W+2)'(OUT_DEPTH))
        else $error("output queue credit exceeded");
`endif

endmodule
